// ===== sv/swlru_pkg.sv =====
// Package for the size-weighted LRU cache directory.
// Holds sizes, request and result types, and sequencer states.
// Used by size_weighted_lru_cache; has no dependencies.
`default_nettype none

package swlru_pkg;

	localparam int ENTRIES     = 16;
	localparam int ALIGN_BYTES = 32 * 1024;
	localparam int TAG_BITS    = 64;

	localparam int SLOT_BITS  = $clog2(ENTRIES);
	localparam int CNT_BITS   = $clog2(ENTRIES + 1);
	localparam int BYTE_BITS  = 33;
	localparam int ALIGN_LOG2 = $clog2(ALIGN_BYTES);

	localparam logic [BYTE_BITS-1:0] CAP_RESET = BYTE_BITS'(60 * 1024 * 1024);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic        op;
		logic [63:0] key_tag;
		logic [31:0] size_bytes;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic                 inserted;
		logic                 victim_valid;
		logic [63:0]          victim_tag;
		logic                 oversize_error;
		logic [BYTE_BITS-1:0] used_bytes;
		logic                 last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT,
		ST_CHECK,
		ST_EVICT_CHK,
		ST_EVICT_WB,
		ST_INSERT
	} state_t;

endpackage

`default_nettype wire

// ===== sv/swlru_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module swlru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/size_weighted_lru_cache.sv =====
// Size-weighted LRU cache directory, top level.
// Depends on swlru_pkg and swlru_ram (tag and size memories).
`default_nettype none

// One request is taken when start is high and busy is low; busy stays high
// until the cycle in which the final result is shown. The tag search reads one
// slot of the tag memory per cycle through its registered read port. A hit stops
// the search at the matching slot and then passes through the hit state. A miss
// searches every slot and then goes through the capacity check, which ends the
// request with an oversize error if the aligned size exceeds capacity, a memory
// read and a write-back per evicted entry, and a last eviction check and the
// insert. Each result is shown in the cycle after the step that makes it.
// Results appear on result for exactly one cycle with result_valid high and
// cannot be held off, so the receiver must take every one. The capacity
// register may be written at any time the block is idle; cfg_ready is always
// high.
module size_weighted_lru_cache (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire swlru_pkg::req_t                       req,
	output logic                                       result_valid,
	output swlru_pkg::rsp_t                            result,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [swlru_pkg::BYTE_BITS-1:0]       cfg_data
);

	localparam int NE = swlru_pkg::ENTRIES;
	localparam int SB = swlru_pkg::SLOT_BITS;
	localparam int CB = swlru_pkg::CNT_BITS;
	localparam int BB = swlru_pkg::BYTE_BITS;
	localparam int TB = swlru_pkg::TAG_BITS;

	localparam logic [BB-1:0] ALIGN_MASK = ~((BB'(1) << swlru_pkg::ALIGN_LOG2) - BB'(1));

	swlru_pkg::state_t state_q, state_d;

	logic [BB-1:0]   cap_q;
	logic [BB-1:0]   occ_q;
	logic [CB-1:0]   count_q;
	logic [NE-1:0]   valid_q;
	logic [SB-1:0]   rank_q [NE];
	logic [SB:0]     idx_q;
	logic [SB-1:0]   cmp_idx_s1;
	logic            cmp_vld_s1;
	logic [SB-1:0]   slot_q;
	logic [SB-1:0]   victim_q;
	logic            op_q;
	logic [TB-1:0]   tag_q;
	logic [BB-1:0]   aligned_q;

	swlru_pkg::rsp_t rsp_q, rsp_d;
	logic            rsp_vld_q, rsp_vld_d;

	logic [SB-1:0]   raddr;
	logic [TB-1:0]   rd_tag;
	logic [BB-1:0]   rd_size;
	logic            ram_we;
	logic [SB-1:0]   free_slot;
	logic [SB-1:0]   victim_slot;
	logic            match;
	logic            scan_end;
	logic            full;
	logic [BB:0]     add_b;
	logic [BB:0]     add_res;
	logic [BB:0]     cmp_a;
	logic            over_cap;
	logic [BB-1:0]   size_ext;

	swlru_ram #(.WIDTH(TB), .DEPTH(NE)) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_slot),
		.wdata (tag_q),
		.raddr (raddr),
		.rdata (rd_tag)
	);

	swlru_ram #(.WIDTH(BB), .DEPTH(NE)) u_size_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_slot),
		.wdata (aligned_q),
		.raddr (raddr),
		.rdata (rd_size)
	);

	assign busy         = (state_q != swlru_pkg::ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = rsp_vld_q;
	assign result       = rsp_q;
	assign full         = (count_q == CB'(NE));
	assign size_ext     = BB'(req.size_bytes) + BB'(swlru_pkg::ALIGN_BYTES - 1);

	// The shared adder subtracts a victim's size during write-back and adds
	// the new aligned size otherwise; one comparator checks against capacity.
	assign add_b    = (state_q == swlru_pkg::ST_EVICT_WB) ? {1'b0, rd_size} : {1'b0, aligned_q};
	assign add_res  = (state_q == swlru_pkg::ST_EVICT_WB) ? ({1'b0, occ_q} - add_b)
	                                                      : ({1'b0, occ_q} + add_b);
	assign cmp_a    = (state_q == swlru_pkg::ST_CHECK) ? {1'b0, aligned_q} : add_res;
	assign over_cap = (cmp_a > {1'b0, cap_q});

	assign match = (state_q == swlru_pkg::ST_SCAN) && cmp_vld_s1 && valid_q[cmp_idx_s1]
	               && (rd_tag == tag_q);
	assign scan_end = cmp_vld_s1 && (cmp_idx_s1 == SB'(NE - 1));

	always_comb begin
		free_slot = '0;
		for (int i = NE - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SB'(i);
			end
		end
	end

	always_comb begin
		victim_slot = '0;
		for (int i = 0; i < NE; i++) begin
			if (valid_q[i] && (rank_q[i] == SB'(count_q - CB'(1)))) begin
				victim_slot = SB'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swlru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rsp_d     = '0;
		rsp_vld_d = 1'b0;
		raddr     = idx_q[SB-1:0];
		ram_we    = 1'b0;
		case (state_q)
			swlru_pkg::ST_IDLE: begin
				if (start) begin
					state_d = swlru_pkg::ST_SCAN;
				end
			end
			swlru_pkg::ST_SCAN: begin
				if (match) begin
					state_d = swlru_pkg::ST_HIT;
				end else if (scan_end) begin
					state_d = swlru_pkg::ST_CHECK;
				end
			end
			swlru_pkg::ST_HIT: begin
				rsp_d.hit        = 1'b1;
				rsp_d.used_bytes = occ_q;
				rsp_d.last       = 1'b1;
				rsp_vld_d        = 1'b1;
				state_d          = swlru_pkg::ST_IDLE;
			end
			swlru_pkg::ST_CHECK: begin
				if (over_cap) begin
					rsp_d.oversize_error = 1'b1;
					rsp_d.used_bytes     = occ_q;
					rsp_d.last           = 1'b1;
					rsp_vld_d            = 1'b1;
					state_d              = swlru_pkg::ST_IDLE;
				end else begin
					state_d = swlru_pkg::ST_EVICT_CHK;
				end
			end
			swlru_pkg::ST_EVICT_CHK: begin
				raddr = victim_slot;
				if ((over_cap || full) && (count_q != '0)) begin
					state_d = swlru_pkg::ST_EVICT_WB;
				end else begin
					state_d = swlru_pkg::ST_INSERT;
				end
			end
			swlru_pkg::ST_EVICT_WB: begin
				rsp_d.victim_valid = 1'b1;
				rsp_d.victim_tag   = 64'(rd_tag);
				rsp_d.used_bytes   = add_res[BB-1:0];
				rsp_vld_d          = 1'b1;
				state_d            = swlru_pkg::ST_EVICT_CHK;
			end
			swlru_pkg::ST_INSERT: begin
				ram_we           = 1'b1;
				rsp_d.inserted   = 1'b1;
				rsp_d.used_bytes = add_res[BB-1:0];
				rsp_d.last       = 1'b1;
				rsp_vld_d        = 1'b1;
				state_d          = swlru_pkg::ST_IDLE;
			end
			default: begin
				state_d = swlru_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= swlru_pkg::CAP_RESET;
			occ_q      <= '0;
			count_q    <= '0;
			valid_q    <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			rsp_vld_q  <= 1'b0;
			for (int i = 0; i < NE; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			rsp_vld_q  <= rsp_vld_d;
			cmp_vld_s1 <= (state_q == swlru_pkg::ST_SCAN) && (idx_q < (SB + 1)'(NE));
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			case (state_q)
				swlru_pkg::ST_IDLE: begin
					idx_q <= '0;
				end
				swlru_pkg::ST_SCAN: begin
					if (idx_q < (SB + 1)'(NE)) begin
						idx_q <= idx_q + (SB + 1)'(1);
					end
				end
				swlru_pkg::ST_HIT: begin
					if (op_q == swlru_pkg::OP_GET) begin
						for (int i = 0; i < NE; i++) begin
							if (valid_q[i] && (rank_q[i] < rank_q[slot_q])) begin
								rank_q[i] <= rank_q[i] + SB'(1);
							end
						end
						rank_q[slot_q] <= '0;
					end
				end
				swlru_pkg::ST_EVICT_WB: begin
					valid_q[victim_q] <= 1'b0;
					count_q           <= count_q - CB'(1);
					occ_q             <= add_res[BB-1:0];
				end
				swlru_pkg::ST_INSERT: begin
					for (int i = 0; i < NE; i++) begin
						if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + SB'(1);
						end
					end
					rank_q[free_slot]  <= '0;
					valid_q[free_slot] <= 1'b1;
					count_q            <= count_q + CB'(1);
					occ_q              <= add_res[BB-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rsp_q      <= rsp_d;
		cmp_idx_s1 <= idx_q[SB-1:0];
		if (state_q == swlru_pkg::ST_IDLE && start) begin
			op_q      <= req.op;
			tag_q     <= req.key_tag[TB-1:0];
			aligned_q <= size_ext & ALIGN_MASK;
		end
		if (match) begin
			slot_q <= cmp_idx_s1;
		end
		if (state_q == swlru_pkg::ST_EVICT_CHK) begin
			victim_q <= victim_slot;
		end
	end

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
		else $error("valid entry count out of step with valid bits");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(NE))
		else $error("entry count exceeds table size");

	a_final_frees_block: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> !busy)
		else $error("block still busy while final result is shown");

	a_victim_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.victim_valid) |-> (!result.last && busy))
		else $error("victim result marked final or shown while idle");

	a_evict_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swlru_pkg::ST_EVICT_WB) |-> valid_q[victim_q])
		else $error("eviction of an empty slot");

endmodule

`default_nettype wire

// ===== verif/size_weighted_lru_cache_test.sv =====
// Self-checking testbench for the size-weighted LRU cache directory.
// A directed table, then random request bursts across capacity settings, checked against an
// in-bench directory predictor; depends on swlru_pkg and size_weighted_lru_cache.
`default_nettype none

module size_weighted_lru_cache_test;

	localparam int QUIET_LIMIT  = 1000;
	localparam int SETTLE_CYC   = 8;
	localparam int TAIL_CYC     = 80;
	localparam int POOL_KEYS    = 24;
	localparam int PHASE_ITEMS  = 21;

	typedef struct {
		bit                              is_cfg;
		logic [swlru_pkg::BYTE_BITS-1:0] cap_value;
		swlru_pkg::req_t                 rq;
		bit                              typed;
		bit                              want_hit;
		bit                              want_ins;
		bit                              want_ovf;
		logic [swlru_pkg::BYTE_BITS-1:0] want_used;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	swlru_pkg::req_t                 req = '0;
	logic                            result_valid;
	swlru_pkg::rsp_t                 result;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [swlru_pkg::BYTE_BITS-1:0] cfg_data = '0;

	logic [63:0]                     dir_tag [swlru_pkg::ENTRIES];
	logic [swlru_pkg::BYTE_BITS-1:0] dir_size [swlru_pkg::ENTRIES];
	bit                              dir_valid [swlru_pkg::ENTRIES];
	int                              dir_rank [swlru_pkg::ENTRIES];
	logic [swlru_pkg::BYTE_BITS-1:0] dir_used = '0;
	logic [swlru_pkg::BYTE_BITS-1:0] dir_capacity = swlru_pkg::CAP_RESET;

	swlru_pkg::rsp_t due_results [$];
	swlru_pkg::rsp_t head;
	swlru_pkg::rsp_t last_final = '0;
	stim_row_t       stim_rows [$];
	logic [63:0]     key_pool [POOL_KEYS];
	int              errors = 0;
	int              quiet_cycles = 0;

	size_weighted_lru_cache u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report($sformatf("%s got %h want %h", what, got, want));
		end
	endtask

	function automatic int free_slot();
		int found;
		found = -1;
		for (int i = swlru_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (!dir_valid[i]) found = i;
		end
		return found;
	endfunction

	function automatic int oldest_slot();
		int found;
		found = -1;
		for (int i = 0; i < swlru_pkg::ENTRIES; i++) begin
			if (dir_valid[i] && (found < 0 || dir_rank[i] > dir_rank[found])) found = i;
		end
		return found;
	endfunction

	// Updates the directory copy for one request and queues the results it causes.
	function automatic void lookup_and_evict(input swlru_pkg::req_t r);
		int              slot;
		int              victim;
		int              old_rank;
		logic [63:0]     aligned;
		swlru_pkg::rsp_t o;
		slot = -1;
		for (int i = 0; i < swlru_pkg::ENTRIES; i++) begin
			if (slot < 0 && dir_valid[i] && dir_tag[i] == r.key_tag) slot = i;
		end
		if (slot >= 0) begin
			if (r.op == swlru_pkg::OP_GET) begin
				old_rank = dir_rank[slot];
				for (int i = 0; i < swlru_pkg::ENTRIES; i++) begin
					if (dir_valid[i] && dir_rank[i] < old_rank) dir_rank[i]++;
				end
				dir_rank[slot] = 0;
			end
			o = '0;
			o.hit = 1'b1;
			o.used_bytes = dir_used;
			o.last = 1'b1;
			due_results.push_back(o);
			return;
		end
		aligned = ((64'(r.size_bytes) + 64'(swlru_pkg::ALIGN_BYTES) - 64'd1)
			/ 64'(swlru_pkg::ALIGN_BYTES)) * 64'(swlru_pkg::ALIGN_BYTES);
		if (aligned > 64'(dir_capacity)) begin
			o = '0;
			o.oversize_error = 1'b1;
			o.used_bytes = dir_used;
			o.last = 1'b1;
			due_results.push_back(o);
			return;
		end
		while ((64'(dir_used) + aligned > 64'(dir_capacity) || free_slot() < 0)
				&& oldest_slot() >= 0) begin
			victim = oldest_slot();
			dir_valid[victim] = 1'b0;
			dir_used = dir_used - dir_size[victim];
			o = '0;
			o.victim_valid = 1'b1;
			o.victim_tag = dir_tag[victim];
			o.used_bytes = dir_used;
			due_results.push_back(o);
		end
		slot = free_slot();
		if (slot < 0) slot = 0;
		for (int i = 0; i < swlru_pkg::ENTRIES; i++) begin
			if (dir_valid[i]) dir_rank[i]++;
		end
		dir_tag[slot] = r.key_tag;
		dir_size[slot] = aligned[swlru_pkg::BYTE_BITS-1:0];
		dir_valid[slot] = 1'b1;
		dir_rank[slot] = 0;
		dir_used = dir_used + aligned[swlru_pkg::BYTE_BITS-1:0];
		o = '0;
		o.inserted = 1'b1;
		o.used_bytes = dir_used;
		o.last = 1'b1;
		due_results.push_back(o);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) begin
				if (result.last) last_final = result;
				if (due_results.size() == 0) begin
					report($sformatf("unexpected result %p", result));
				end else begin
					head = due_results.pop_front();
					check_field("hit", result.hit, head.hit);
					check_field("inserted", result.inserted, head.inserted);
					check_field("victim_valid", result.victim_valid, head.victim_valid);
					check_field("victim_tag", result.victim_tag, head.victim_tag);
					check_field("oversize_error", result.oversize_error, head.oversize_error);
					check_field("used_bytes", result.used_bytes, head.used_bytes);
					check_field("last", result.last, head.last);
				end
			end
			if (start && !busy) lookup_and_evict(req);
			if (cfg_valid && cfg_ready) dir_capacity = cfg_data;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no request, result or register write for %0d cycles",
					QUIET_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic issue(input swlru_pkg::req_t r);
		@(negedge clk);
		start = 1'b1;
		req = r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (due_results.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [swlru_pkg::BYTE_BITS-1:0] value);
		drain();
		repeat (SETTLE_CYC) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic add_req(input logic op, input logic [63:0] key, input logic [31:0] size);
		stim_row_t row;
		row = '{default: '0};
		row.rq.op = op;
		row.rq.key_tag = key;
		row.rq.size_bytes = size;
		stim_rows.push_back(row);
	endtask

	task automatic add_typed(input logic op, input logic [63:0] key, input logic [31:0] size,
			input bit hit, input bit ins, input bit ovf,
			input logic [swlru_pkg::BYTE_BITS-1:0] used);
		stim_row_t row;
		row = '{default: '0};
		row.rq.op = op;
		row.rq.key_tag = key;
		row.rq.size_bytes = size;
		row.typed = 1'b1;
		row.want_hit = hit;
		row.want_ins = ins;
		row.want_ovf = ovf;
		row.want_used = used;
		stim_rows.push_back(row);
	endtask

	task automatic add_cap(input logic [swlru_pkg::BYTE_BITS-1:0] value);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.cap_value = value;
		stim_rows.push_back(row);
	endtask

	function automatic swlru_pkg::req_t random_request();
		swlru_pkg::req_t r;
		int              pick;
		int unsigned     size;
		r.op = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 85) begin
			r.key_tag = key_pool[$urandom_range(0, POOL_KEYS - 1)];
		end else begin
			r.key_tag = {$urandom, $urandom};
		end
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			size = $urandom_range(0, 4) * swlru_pkg::ALIGN_BYTES;
			if ($urandom_range(0, 1)) size += $urandom_range(1, swlru_pkg::ALIGN_BYTES - 1);
		end else if (pick < 9) begin
			size = $urandom_range(0, 32'h00FF_FFFF);
		end else begin
			size = $urandom;
		end
		r.size_bytes = size;
		return r;
	endfunction

	initial begin
		logic [swlru_pkg::BYTE_BITS-1:0] phase_caps [5];
		int                              burst;
		for (int i = 0; i < swlru_pkg::ENTRIES; i++) begin
			dir_valid[i] = 1'b0;
			dir_rank[i] = 0;
		end
		for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};
		phase_caps[0] = swlru_pkg::BYTE_BITS'(4 * swlru_pkg::ALIGN_BYTES);
		phase_caps[1] = 33'h1_0000_0000;
		phase_caps[2] = {1'b0, $urandom};
		phase_caps[3] = swlru_pkg::CAP_RESET;
		phase_caps[4] = swlru_pkg::BYTE_BITS'(20 * swlru_pkg::ALIGN_BYTES);

		add_typed(swlru_pkg::OP_GET, 64'h0, 32'h0, 1'b0, 1'b1, 1'b0, 33'h0);
		add_typed(swlru_pkg::OP_GET, 64'h0, 32'h5, 1'b1, 1'b0, 1'b0, 33'h0);
		add_typed(swlru_pkg::OP_PUT, '1, 32'h1, 1'b0, 1'b1, 1'b0, 33'h8000);
		add_typed(swlru_pkg::OP_PUT, '1, 32'h0, 1'b1, 1'b0, 1'b0, 33'h8000);
		add_typed(swlru_pkg::OP_GET, 64'h1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 33'h8000);
		add_typed(swlru_pkg::OP_GET, 64'h2, 32'd32769, 1'b0, 1'b1, 1'b0, 33'h18000);
		add_cap(33'h1_0000_0000);
		add_typed(swlru_pkg::OP_PUT, 64'h5, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0,
			33'h1_0000_0000);
		add_cap(33'h0);
		add_typed(swlru_pkg::OP_GET, 64'h6, 32'h0, 1'b0, 1'b1, 1'b0, 33'h0);
		add_typed(swlru_pkg::OP_GET, 64'h7, 32'h1, 1'b0, 1'b0, 1'b1, 33'h0);
		add_cap(swlru_pkg::CAP_RESET);
		for (int k = 0; k < swlru_pkg::ENTRIES - 1; k++) begin
			add_req(swlru_pkg::OP_PUT, 64'h10 + 64'(k), 32'(k * 4096));
		end
		add_req(swlru_pkg::OP_GET, 64'h6, 32'h0);
		add_req(swlru_pkg::OP_PUT, 64'h1F, 32'h0);
		add_cap(33'h1_0000);
		add_req(swlru_pkg::OP_GET, 64'h11, 32'h0);
		add_req(swlru_pkg::OP_PUT, 64'h20, 32'h8000);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[n]) begin
			if (stim_rows[n].is_cfg) begin
				write_capacity(stim_rows[n].cap_value);
			end else begin
				issue(stim_rows[n].rq);
				drain();
				if (stim_rows[n].typed) begin
					check_field($sformatf("row %0d hit", n), last_final.hit,
						stim_rows[n].want_hit);
					check_field($sformatf("row %0d inserted", n), last_final.inserted,
						stim_rows[n].want_ins);
					check_field($sformatf("row %0d oversize_error", n),
						last_final.oversize_error, stim_rows[n].want_ovf);
					check_field($sformatf("row %0d used_bytes", n), last_final.used_bytes,
						stim_rows[n].want_used);
				end
			end
		end

		for (int p = 0; p < 5; p++) begin
			write_capacity(phase_caps[p]);
			burst = $urandom_range(1, 8);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				issue(random_request());
				burst--;
				if (burst == 0) begin
					burst = $urandom_range(1, 8);
					if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 30));
				end
			end
		end

		drain();
		repeat (TAIL_CYC) @(negedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
